>>> rtl/control_code_text_tokenizer_unit_assert.svh
// assertion macros used by the tokenizer back stage
`ifndef CONTROL_CODE_TEXT_TOKENIZER_UNIT_ASSERT_SVH
`define CONTROL_CODE_TEXT_TOKENIZER_UNIT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define CCTT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CCTT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define CCTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cctt_pkg.sv
// types, byte codes and sizes shared by the tokenizer modules
package cctt_pkg;

    localparam int BYTE_W              = 8;
    localparam int KIND_W              = 4;
    localparam int ARG_B_W             = 16;
    localparam int OUT_OFFSET_W        = 16;
    localparam int DEFAULT_OFFSET_BITS = 16;
    localparam int WINDOW_DEPTH        = 4;
    localparam int FILL_W              = 3;
    localparam int QUEUE_DEPTH         = 2;
    localparam int NAME_LEN_W          = 8;
    localparam int NAME_LIMIT          = 255;

    localparam logic [7:0] CODE_NUL   = 8'h00;
    localparam logic [7:0] CODE_PAGE  = 8'hF6;
    localparam logic [7:0] CODE_IMAGE = 8'hF7;
    localparam logic [7:0] CODE_FONT  = 8'hF9;
    localparam logic [7:0] CODE_COLOR = 8'hFA;
    localparam logic [7:0] CODE_POS   = 8'hFB;
    localparam logic [7:0] CODE_EOL_L = 8'hFC;
    localparam logic [7:0] CODE_EOL_C = 8'hFD;
    localparam logic [7:0] PRINT_LO   = 8'h20;
    localparam logic [7:0] PRINT_HI   = 8'h7F;

    typedef enum logic [3:0] {
        CLS_NUL,
        CLS_PAGE,
        CLS_IMAGE,
        CLS_FONT,
        CLS_COLOR,
        CLS_POS,
        CLS_EOL_L,
        CLS_EOL_C,
        CLS_PRINT,
        CLS_OTHER
    } cls_t;

    typedef enum logic [3:0] {
        KIND_TEXT      = 4'd0,
        KIND_POSITION  = 4'd1,
        KIND_EOL_LEFT  = 4'd2,
        KIND_EOL_CTR   = 4'd3,
        KIND_NEWLINE   = 4'd4,
        KIND_PAGE_END  = 4'd5,
        KIND_FONT      = 4'd6,
        KIND_COLOR     = 4'd7,
        KIND_IMG_START = 4'd8,
        KIND_NAME_CHAR = 4'd9,
        KIND_NAME_END  = 4'd10,
        KIND_UNKNOWN   = 4'd11,
        KIND_REC_END   = 4'd12
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        cls_t              cls;
        logic              last;
    } qitem_t;

endpackage

>>> rtl/cctt_if.sv
// valid/ready channel interfaces for record bytes and tokens

interface cctt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       record_last;

    modport source (output valid, output data_byte, output record_last, input ready);
    modport sink   (input valid, input data_byte, input record_last, output ready);
endinterface

interface cctt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [7:0]  arg_a;
    logic [15:0] arg_b;
    logic [15:0] byte_offset;
    logic        run_first;
    logic        last_result;

    modport source (output valid, output kind, output arg_a, output arg_b,
                    output byte_offset, output run_first, output last_result,
                    input ready);
    modport sink   (input valid, input kind, input arg_a, input arg_b,
                    input byte_offset, input run_first, input last_result,
                    output ready);
endinterface

>>> rtl/control_code_text_tokenizer_unit.sv
// top level of the control code text tokenizer
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------------
//  bytes    | in  | valid / ready | data_byte[7:0], record_last
//  tokens   | out | valid / ready | kind[3:0], arg_a[7:0], arg_b[15:0],
//           |     |               | byte_offset[15:0], run_first, last_result
//
//  one byte per cycle while the token output takes results and each byte decides at most
//  one token; every further token of the same byte (name chars after an image start, the
//  drain at record end) holds off the next byte in the single token decoder of the back stage
//  bytes pass the front register and the queue, tokens the back stage result register
//  rst_n clears all control state at once; window and result payload are not reset
//  a stalled token output holds the back stage, the queue keeps the front taking bytes until it fills
module control_code_text_tokenizer_unit #(
    parameter int OFFSET_BITS = cctt_pkg::DEFAULT_OFFSET_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    cctt_in_if.sink     bytes,
    cctt_out_if.source  tokens
);

    // front to queue transfer
    logic             f_valid;
    cctt_pkg::qitem_t f_item;
    logic             f_ready;

    // queue to back transfer
    logic             q_valid;
    cctt_pkg::qitem_t q_item;
    logic             q_ready;

    // classify each byte as it arrives
    cctt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .item_valid (f_valid),
        .item       (f_item),
        .item_ready (f_ready)
    );

    // decouples byte intake from token output stalls
    cctt_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_item  (f_item),
        .wr_ready (f_ready),
        .rd_valid (q_valid),
        .rd_item  (q_item),
        .rd_ready (q_ready)
    );

    // lookahead window, greedy token decisions, result register
    cctt_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_ready (q_ready),
        .tokens  (tokens)
    );

endmodule

>>> rtl/cctt_front.sv
// front stage: takes record bytes and registers them with their byte class
module cctt_front (
    input  logic              clk,
    input  logic              rst_n,
    cctt_in_if.sink           bytes,
    output logic              item_valid,
    output cctt_pkg::qitem_t  item,
    input  logic              item_ready
);

    logic             valid_reg;
    logic             valid_next;
    cctt_pkg::qitem_t item_reg;
    logic             accept;

    function automatic cctt_pkg::cls_t classify(input logic [7:0] b);
        cctt_pkg::cls_t c;
        unique case (b)
            cctt_pkg::CODE_NUL:   c = cctt_pkg::CLS_NUL;
            cctt_pkg::CODE_PAGE:  c = cctt_pkg::CLS_PAGE;
            cctt_pkg::CODE_IMAGE: c = cctt_pkg::CLS_IMAGE;
            cctt_pkg::CODE_FONT:  c = cctt_pkg::CLS_FONT;
            cctt_pkg::CODE_COLOR: c = cctt_pkg::CLS_COLOR;
            cctt_pkg::CODE_POS:   c = cctt_pkg::CLS_POS;
            cctt_pkg::CODE_EOL_L: c = cctt_pkg::CLS_EOL_L;
            cctt_pkg::CODE_EOL_C: c = cctt_pkg::CLS_EOL_C;
            default:
            begin
                if (b >= cctt_pkg::PRINT_LO && b <= cctt_pkg::PRINT_HI)
                begin
                    c = cctt_pkg::CLS_PRINT;
                end
                else
                begin
                    c = cctt_pkg::CLS_OTHER;
                end
            end
        endcase
        return c;
    endfunction

    assign bytes.ready = !valid_reg || item_ready;
    assign accept      = bytes.valid && bytes.ready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data <= bytes.data_byte;
            item_reg.cls  <= classify(bytes.data_byte);
            item_reg.last <= bytes.record_last;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/cctt_fifo.sv
// short queue of classified bytes between the front and back stages
module cctt_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    input  cctt_pkg::qitem_t  wr_item,
    output logic              wr_ready,
    output logic              rd_valid,
    output cctt_pkg::qitem_t  rd_item,
    input  logic              rd_ready
);

    localparam int DEPTH = cctt_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cctt_pkg::qitem_t   mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

>>> rtl/cctt_back.sv
// back stage: lookahead window, token decisions and the result register
`include "control_code_text_tokenizer_unit_assert.svh"

module cctt_back #(
    parameter int OFFSET_BITS = cctt_pkg::DEFAULT_OFFSET_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  cctt_pkg::qitem_t  q_item,
    output logic              q_ready,
    cctt_out_if.source        tokens
);

    localparam int WD  = cctt_pkg::WINDOW_DEPTH;
    localparam int FW  = cctt_pkg::FILL_W;
    localparam int NLW = cctt_pkg::NAME_LEN_W;

    // window and control state
    logic [7:0]                  win_data_reg [WD];
    cctt_pkg::cls_t              win_cls_reg  [WD];
    logic [FW-1:0]               fill_reg;
    logic [FW-1:0]               fill_next;
    logic [OFFSET_BITS-1:0]      offset_reg;
    logic [OFFSET_BITS-1:0]      offset_next;
    logic                        run_reg;
    logic                        run_next;
    logic                        name_mode_reg;
    logic                        name_mode_next;
    logic [NLW-1:0]              name_len_reg;
    logic [NLW-1:0]              name_len_next;
    logic                        skip_reg;
    logic                        skip_next;
    logic                        drain_reg;
    logic                        drain_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    // result register
    cctt_pkg::kind_t             kind_reg;
    logic [7:0]                  arg_a_reg;
    logic [15:0]                 arg_b_reg;
    logic [15:0]                 offset_out_reg;
    logic                        first_reg;
    logic                        last_reg;

    // working signals
    logic                        adv;
    logic                        pending;
    logic                        take;
    logic                        do_proc;
    logic                        eff_drain;
    logic [FW-1:0]               eff_fill;
    logic [7:0]                  ew_data [WD];
    cctt_pkg::cls_t              ew_cls  [WD];
    logic [7:0]                  nw_data [WD];
    cctt_pkg::cls_t              nw_cls  [WD];
    cctt_pkg::kind_t             tok_kind;
    logic [7:0]                  tok_a;
    logic [15:0]                 tok_b;
    logic [15:0]                 tok_offset;
    logic                        tok_first;
    logic                        tok_last;
    logic                        rec_end;
    logic [FW-1:0]               cons;
    logic [FW-1:0]               new_fill;
    logic [NLW:0]                len_inc;
    logic [OFFSET_BITS:0]        off_sum;
    logic [OFFSET_BITS-1:0]      off_adv;
    logic [31:0]                 off_wide;
    logic                        n_name;
    logic [NLW-1:0]              n_len;
    logic                        n_skip;
    logic                        n_run;

    // work is left over from the last byte: drain, or name chars still in the window
    assign pending = drain_reg || (name_mode_reg && fill_reg != '0);
    assign adv     = !out_valid_reg || tokens.ready;
    assign take    = !pending && q_valid && adv;
    assign q_ready = !pending && adv;
    assign do_proc = pending ? adv
                   : (take && (q_item.last || name_mode_reg || fill_reg == FW'(WD - 1)));

    assign eff_fill  = pending ? fill_reg : fill_reg + 1'b1;
    assign eff_drain = drain_reg || (take && q_item.last);

    // window with the incoming byte placed behind the held ones
    always_comb
    begin
        for (int i = 0; i < WD; i++)
        begin
            ew_data[i] = win_data_reg[i];
            ew_cls[i]  = win_cls_reg[i];
            if (!pending && fill_reg[1:0] == 2'(i))
            begin
                ew_data[i] = q_item.data;
                ew_cls[i]  = q_item.cls;
            end
        end
    end

    // token decision at the window head
    always_comb
    begin
        len_inc   = {1'b0, name_len_reg} + 1'b1;
        tok_kind  = cctt_pkg::KIND_UNKNOWN;
        tok_a     = '0;
        tok_b     = '0;
        tok_first = 1'b0;
        rec_end   = 1'b0;
        cons      = FW'(1);
        n_name    = name_mode_reg;
        n_len     = name_len_reg;
        n_skip    = skip_reg;
        n_run     = run_reg;
        if (eff_drain && eff_fill == '0)
        begin
            rec_end  = 1'b1;
            tok_kind = cctt_pkg::KIND_REC_END;
            cons     = '0;
        end
        else if (name_mode_reg)
        begin
            if (skip_reg || ew_cls[0] == cctt_pkg::CLS_NUL)
            begin
                tok_kind = cctt_pkg::KIND_NAME_END;
                n_name   = 1'b0;
                n_skip   = 1'b0;
                n_len    = '0;
            end
            else
            begin
                tok_kind = cctt_pkg::KIND_NAME_CHAR;
                tok_a    = ew_data[0];
                n_len    = len_inc[NLW-1:0];
                if (len_inc >= (NLW+1)'(cctt_pkg::NAME_LIMIT))
                begin
                    n_skip = 1'b1;
                end
            end
        end
        else if (eff_fill >= FW'(4) && ew_cls[1] == cctt_pkg::CLS_POS)
        begin
            tok_kind = cctt_pkg::KIND_POSITION;
            tok_a    = ew_data[0];
            tok_b    = {ew_data[3], ew_data[2]};
            cons     = FW'(4);
            n_run    = 1'b0;
        end
        else if ((ew_cls[0] == cctt_pkg::CLS_EOL_L || ew_cls[0] == cctt_pkg::CLS_EOL_C)
                 && eff_fill >= FW'(2) && ew_cls[1] == cctt_pkg::CLS_NUL)
        begin
            tok_kind = (ew_cls[0] == cctt_pkg::CLS_EOL_L) ? cctt_pkg::KIND_EOL_LEFT
                                                          : cctt_pkg::KIND_EOL_CTR;
            cons     = FW'(2);
            n_run    = 1'b0;
        end
        else if (ew_cls[0] == cctt_pkg::CLS_NUL)
        begin
            tok_kind = cctt_pkg::KIND_NEWLINE;
            n_run    = 1'b0;
        end
        else if (ew_cls[0] == cctt_pkg::CLS_PAGE)
        begin
            tok_kind = cctt_pkg::KIND_PAGE_END;
            n_run    = 1'b0;
        end
        else if ((ew_cls[0] == cctt_pkg::CLS_FONT || ew_cls[0] == cctt_pkg::CLS_COLOR)
                 && eff_fill >= FW'(2))
        begin
            tok_kind = (ew_cls[0] == cctt_pkg::CLS_FONT) ? cctt_pkg::KIND_FONT
                                                         : cctt_pkg::KIND_COLOR;
            tok_a    = ew_data[1];
            cons     = FW'(2);
            n_run    = 1'b0;
        end
        else if (ew_cls[0] == cctt_pkg::CLS_IMAGE)
        begin
            tok_kind = cctt_pkg::KIND_IMG_START;
            n_run    = 1'b0;
            n_name   = 1'b1;
            n_len    = '0;
            n_skip   = 1'b0;
        end
        else if (ew_cls[0] == cctt_pkg::CLS_PRINT)
        begin
            tok_kind  = cctt_pkg::KIND_TEXT;
            tok_a     = ew_data[0];
            tok_first = !run_reg;
            n_run     = 1'b1;
        end
        else
        begin
            tok_kind = cctt_pkg::KIND_UNKNOWN;
            tok_a    = ew_data[0];
            n_run    = 1'b0;
        end
    end

    // consume: shift the window, move the saturating offset
    always_comb
    begin
        for (int i = 0; i < WD; i++)
        begin
            nw_data[i] = ew_data[i];
            nw_cls[i]  = ew_cls[i];
            for (int j = 1; j <= WD; j++)
            begin
                if (cons == FW'(j) && i + j < WD)
                begin
                    nw_data[i] = ew_data[(i + j) % WD];
                    nw_cls[i]  = ew_cls[(i + j) % WD];
                end
            end
        end
    end

    assign new_fill = eff_fill - cons;
    assign off_sum  = {1'b0, offset_reg} + {{(OFFSET_BITS + 1 - FW){1'b0}}, cons};
    assign off_adv  = off_sum[OFFSET_BITS] ? '1 : off_sum[OFFSET_BITS-1:0];
    assign off_wide = 32'(offset_reg);
    assign tok_offset = (off_wide > 32'h0000_FFFF) ? 16'hFFFF : off_wide[15:0];
    // the byte's results end once nothing is left to decide before the next byte
    assign tok_last = rec_end || (!eff_drain && !(n_name && new_fill != '0));

    always_comb
    begin
        fill_next      = fill_reg;
        offset_next    = offset_reg;
        run_next       = run_reg;
        name_mode_next = name_mode_reg;
        name_len_next  = name_len_reg;
        skip_next      = skip_reg;
        drain_next     = drain_reg;
        out_valid_next = tokens.ready ? 1'b0 : out_valid_reg;
        if (do_proc)
        begin
            out_valid_next = 1'b1;
            if (rec_end)
            begin
                fill_next      = '0;
                offset_next    = '0;
                run_next       = 1'b0;
                name_mode_next = 1'b0;
                name_len_next  = '0;
                skip_next      = 1'b0;
                drain_next     = 1'b0;
            end
            else
            begin
                fill_next      = new_fill;
                offset_next    = off_adv;
                run_next       = n_run;
                name_mode_next = n_name;
                name_len_next  = n_len;
                skip_next      = n_skip;
                drain_next     = eff_drain;
            end
        end
        else if (take)
        begin
            fill_next = eff_fill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            offset_reg    <= '0;
            run_reg       <= 1'b0;
            name_mode_reg <= 1'b0;
            name_len_reg  <= '0;
            skip_reg      <= 1'b0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            offset_reg    <= offset_next;
            run_reg       <= run_next;
            name_mode_reg <= name_mode_next;
            name_len_reg  <= name_len_next;
            skip_reg      <= skip_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_proc)
        begin
            for (int i = 0; i < WD; i++)
            begin
                win_data_reg[i] <= nw_data[i];
                win_cls_reg[i]  <= nw_cls[i];
            end
            kind_reg       <= tok_kind;
            arg_a_reg      <= tok_a;
            arg_b_reg      <= tok_b;
            offset_out_reg <= tok_offset;
            first_reg      <= tok_first;
            last_reg       <= tok_last;
        end
        else if (take)
        begin
            for (int i = 0; i < WD; i++)
            begin
                win_data_reg[i] <= ew_data[i];
                win_cls_reg[i]  <= ew_cls[i];
            end
        end
    end

    assign tokens.valid       = out_valid_reg;
    assign tokens.kind        = kind_reg;
    assign tokens.arg_a       = arg_a_reg;
    assign tokens.arg_b       = arg_b_reg;
    assign tokens.byte_offset = offset_out_reg;
    assign tokens.run_first   = first_reg;
    assign tokens.last_result = last_reg;

    `CCTT_ASSERT_ALWAYS(a_fill_below_window, fill_reg <= FW'(WD - 1), "window left full")
    `CCTT_ASSERT_ALWAYS(a_skip_in_name, !skip_reg || name_mode_reg, "skip outside name")
    `CCTT_ASSERT_SAME(a_rec_end_last, out_valid_reg && kind_reg == cctt_pkg::KIND_REC_END,
        last_reg, "record end not last result")
    `CCTT_ASSERT_SAME(a_first_on_text, out_valid_reg && first_reg,
        kind_reg == cctt_pkg::KIND_TEXT, "run start on non-text token")
    `CCTT_ASSERT_NEXT(a_last_drains, take && q_item.last, drain_reg, "record end not drained")

endmodule

>>> sim/tb_control_code_text_tokenizer_unit.sv
`timescale 1ns / 1ps
// testbench for the control code text tokenizer: directed rows, random records, a full name
module tb_control_code_text_tokenizer_unit;

    // one token as it leaves the block, field for field
    typedef struct packed {
        cctt_pkg::kind_t kind;
        logic [7:0]      arg_a;
        logic [15:0]     arg_b;
        logic [15:0]     byte_offset;
        logic            run_first;
        logic            last_result;
    } token_t;

    // one directed byte; typed rows are single-byte records whose token is spelt out here
    typedef struct packed {
        logic [7:0]      data;
        logic            last;
        logic            typed;
        cctt_pkg::kind_t kind;
        logic [7:0]      arg_a;
        logic            run_first;
    } row_t;

    localparam int unsigned OFFSET_TOP   = 65535;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_ITEMS = 168;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned REPORT_LIMIT = 10;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cctt_in_if  byte_ch ();
    cctt_out_if token_ch ();

    control_code_text_tokenizer_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (byte_ch),
        .tokens (token_ch)
    );

    // percentage of cycles in which each side idles, set per phase
    int unsigned tx_idle = 0;
    int unsigned rx_idle = 0;
    // one-shot request for the long receiver hold-off
    logic        hold_req = 1'b0;
    int unsigned fault_count = 0;

    // lookahead window and parser state of the predictor
    logic [7:0]  win [4];
    int unsigned win_fill;
    int unsigned head_offset;
    logic        run_open;
    logic        name_open;
    int unsigned name_count;
    logic        name_skip;

    token_t      step_tokens [$];
    token_t      awaited [$];
    logic [7:0]  byte_plan [$];

    // directed rows: single-byte records (reset state, extremes, prefix without argument,
    // record ending inside a name), then one record of all kinds but newline and unknown
    row_t directed_rows [24] = '{
        '{8'h00, 1'b1, 1'b1, cctt_pkg::KIND_NEWLINE,   8'h00, 1'b0},
        '{8'hFF, 1'b1, 1'b1, cctt_pkg::KIND_UNKNOWN,   8'hFF, 1'b0},
        '{8'hF9, 1'b1, 1'b1, cctt_pkg::KIND_UNKNOWN,   8'hF9, 1'b0},
        '{8'h7F, 1'b1, 1'b1, cctt_pkg::KIND_TEXT,      8'h7F, 1'b1},
        '{8'h20, 1'b1, 1'b1, cctt_pkg::KIND_TEXT,      8'h20, 1'b1},
        '{8'hF7, 1'b1, 1'b1, cctt_pkg::KIND_IMG_START, 8'h00, 1'b0},
        '{8'h41, 1'b0, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0},
        '{8'h00, 1'b0, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0},
        '{8'hFB, 1'b0, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0},
        '{8'hFF, 1'b0, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0},
        '{8'hFF, 1'b0, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0},
        '{8'hFC, 1'b0, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0},
        '{8'h00, 1'b0, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0},
        '{8'hFD, 1'b0, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0},
        '{8'h00, 1'b0, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0},
        '{8'hF9, 1'b0, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0},
        '{8'h00, 1'b0, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0},
        '{8'hFA, 1'b0, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0},
        '{8'h80, 1'b0, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0},
        '{8'hF6, 1'b0, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0},
        '{8'hF7, 1'b0, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0},
        '{8'h61, 1'b0, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0},
        '{8'h00, 1'b0, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0},
        '{8'h20, 1'b1, 1'b0, cctt_pkg::KIND_TEXT,      8'h00, 1'b0}
    };

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic token_t make_token(cctt_pkg::kind_t k, logic [7:0] a, logic [15:0] b,
                                          logic [15:0] off, logic first, logic lastr);
        token_t t;
        t.kind        = k;
        t.arg_a       = a;
        t.arg_b       = b;
        t.byte_offset = off;
        t.run_first   = first;
        t.last_result = lastr;
        return t;
    endfunction

    // append one byte to the planned record
    function automatic void plan_byte(logic [7:0] b);
        byte_plan = {byte_plan, b};
    endfunction

    // append one token to those the checker waits for
    function automatic void await_token(token_t t);
        awaited = {awaited, t};
    endfunction

    // every token carries the offset of the window head when it is decided
    function automatic void emit_token(cctt_pkg::kind_t k, logic [7:0] a, logic [15:0] b,
                                       logic first);
        step_tokens = {step_tokens, make_token(k, a, b, head_offset[15:0], first, 1'b0)};
    endfunction

    function automatic void clear_parser();
        win_fill    = 0;
        head_offset = 0;
        run_open    = 1'b0;
        name_open   = 1'b0;
        name_count  = 0;
        name_skip   = 1'b0;
    endfunction

    // drop k bytes off the window head, the offset saturates
    function automatic void advance(int unsigned k);
        if (k > win_fill)
            k = win_fill;
        for (int i = 0; i + k < 4; i++)
            win[i] = win[i + k];
        win_fill -= k;
        head_offset = (head_offset + k > OFFSET_TOP) ? OFFSET_TOP : head_offset + k;
    endfunction

    // greedy decision on the window head, precedence as in the block's description
    function automatic void decide_head();
        logic [7:0] b;
        b = win[0];
        if (name_open)
        begin
            // terminator, or the byte after a full-length name, is swallowed
            if (name_skip || b == cctt_pkg::CODE_NUL)
            begin
                emit_token(cctt_pkg::KIND_NAME_END, 8'h00, 16'h0000, 1'b0);
                name_open  = 1'b0;
                name_skip  = 1'b0;
                name_count = 0;
            end
            else
            begin
                emit_token(cctt_pkg::KIND_NAME_CHAR, b, 16'h0000, 1'b0);
                name_count++;
                if (name_count >= cctt_pkg::NAME_LIMIT)
                    name_skip = 1'b1;
            end
            advance(1);
        end
        else if (win_fill >= 4 && win[1] == cctt_pkg::CODE_POS)
        begin
            run_open = 1'b0;
            emit_token(cctt_pkg::KIND_POSITION, b, {win[3], win[2]}, 1'b0);
            advance(4);
        end
        else if ((b == cctt_pkg::CODE_EOL_L || b == cctt_pkg::CODE_EOL_C) && win_fill >= 2
                 && win[1] == cctt_pkg::CODE_NUL)
        begin
            run_open = 1'b0;
            emit_token(b == cctt_pkg::CODE_EOL_L ? cctt_pkg::KIND_EOL_LEFT
                                                 : cctt_pkg::KIND_EOL_CTR,
                       8'h00, 16'h0000, 1'b0);
            advance(2);
        end
        else if (b == cctt_pkg::CODE_NUL || b == cctt_pkg::CODE_PAGE)
        begin
            run_open = 1'b0;
            emit_token(b == cctt_pkg::CODE_NUL ? cctt_pkg::KIND_NEWLINE
                                               : cctt_pkg::KIND_PAGE_END,
                       8'h00, 16'h0000, 1'b0);
            advance(1);
        end
        else if ((b == cctt_pkg::CODE_FONT || b == cctt_pkg::CODE_COLOR) && win_fill >= 2)
        begin
            run_open = 1'b0;
            emit_token(b == cctt_pkg::CODE_FONT ? cctt_pkg::KIND_FONT : cctt_pkg::KIND_COLOR,
                       win[1], 16'h0000, 1'b0);
            advance(2);
        end
        else if (b == cctt_pkg::CODE_IMAGE)
        begin
            run_open = 1'b0;
            emit_token(cctt_pkg::KIND_IMG_START, 8'h00, 16'h0000, 1'b0);
            name_open  = 1'b1;
            name_count = 0;
            name_skip  = 1'b0;
            advance(1);
        end
        else if (b >= cctt_pkg::PRINT_LO && b <= cctt_pkg::PRINT_HI)
        begin
            emit_token(cctt_pkg::KIND_TEXT, b, 16'h0000, !run_open);
            run_open = 1'b1;
            advance(1);
        end
        else
        begin
            run_open = 1'b0;
            emit_token(cctt_pkg::KIND_UNKNOWN, b, 16'h0000, 1'b0);
            advance(1);
        end
    endfunction

    // tokens caused by one accepted byte, last one flagged
    function automatic void tokenize_byte(logic [7:0] d, logic l);
        step_tokens.delete();
        while (win_fill >= 4)
            decide_head();
        win[win_fill] = d;
        win_fill++;
        while (win_fill > 0 && (name_open || win_fill == 4 || l))
            decide_head();
        if (l)
        begin
            emit_token(cctt_pkg::KIND_REC_END, 8'h00, 16'h0000, 1'b0);
            clear_parser();
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last_result = 1'b1;
    endfunction

    function automatic void queue_prediction();
        foreach (step_tokens[i])
            await_token(step_tokens[i]);
    endfunction

    // image start, n name chars, then a tail byte; a zero tail ends the name
    function automatic void add_name(int unsigned n, logic [7:0] tail);
        plan_byte(cctt_pkg::CODE_IMAGE);
        repeat (n)
            plan_byte(8'($urandom_range(1, 255)));
        plan_byte(tail);
    endfunction

    // one well-formed token with random content, or a stray or broken one
    function automatic void add_token();
        int unsigned n;
        logic [7:0]  b;
        case ($urandom_range(0, 11)) inside
            0, 1, 11:
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    plan_byte(8'($urandom_range(cctt_pkg::PRINT_LO, cctt_pkg::PRINT_HI)));
            end
            2:
            begin
                plan_byte(8'($urandom_range(0, 255)));
                plan_byte(cctt_pkg::CODE_POS);
                plan_byte(8'($urandom_range(0, 255)));
                plan_byte(8'($urandom_range(0, 255)));
            end
            3:
            begin
                plan_byte($urandom_range(0, 1) ? cctt_pkg::CODE_EOL_L : cctt_pkg::CODE_EOL_C);
                plan_byte(cctt_pkg::CODE_NUL);
            end
            4: plan_byte(cctt_pkg::CODE_NUL);
            5: plan_byte(cctt_pkg::CODE_PAGE);
            6:
            begin
                plan_byte($urandom_range(0, 1) ? cctt_pkg::CODE_FONT : cctt_pkg::CODE_COLOR);
                plan_byte(8'($urandom_range(0, 255)));
            end
            7:
            begin
                // mostly terminated names, now and then one left open
                b = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
                                                : cctt_pkg::CODE_NUL;
                add_name($urandom_range(0, 10), b);
            end
            8:
            begin
                b = $urandom_range(0, 1) ? 8'($urandom_range(8'h01, 8'h1F))
                                         : 8'($urandom_range(8'h80, 8'hFF));
                if (b >= cctt_pkg::CODE_PAGE && b <= cctt_pkg::CODE_EOL_C && b != 8'hF8)
                    b = 8'hFF;
                plan_byte(b);
            end
            9: plan_byte(8'($urandom_range(0, 255)));
            default:
            begin
                // line end lead-in without its zero byte
                plan_byte($urandom_range(0, 1) ? cctt_pkg::CODE_EOL_L : cctt_pkg::CODE_EOL_C);
                plan_byte(8'($urandom_range(1, 255)));
            end
        endcase
    endfunction

    function automatic void report_fault(string what, token_t want, token_t got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
        begin
            $write("%0t %s: expected kind %0d a %h b %h off %0d first %b last %b",
                   $realtime, what, want.kind, want.arg_a, want.arg_b, want.byte_offset,
                   want.run_first, want.last_result);
            $display(", got kind %0d a %h b %h off %0d first %b last %b",
                     got.kind, got.arg_a, got.arg_b, got.byte_offset, got.run_first,
                     got.last_result);
        end
    endfunction

    // one byte transfer, with random idle cycles in front
    task automatic send_byte(input logic [7:0] d, input logic l);
        while ($urandom_range(99) < tx_idle)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= d;
        byte_ch.record_last <= l;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
    endtask

    // the planned bytes as one record, the last byte closes it
    task automatic send_plan();
        foreach (byte_plan[i])
        begin
            send_byte(byte_plan[i], i == byte_plan.size() - 1);
            tokenize_byte(byte_plan[i], i == byte_plan.size() - 1);
            queue_prediction();
        end
    endtask

    // random records until about budget bytes have gone in
    task automatic run_records(input int unsigned budget);
        int unsigned sent;
        int unsigned cut;
        sent = 0;
        while (sent < budget)
        begin
            byte_plan.delete();
            repeat ($urandom_range(1, 8))
                add_token();
            // now and then cut one or two bytes off the record, which can break its last token
            if ($urandom_range(0, 7) == 0 && byte_plan.size() > 1)
            begin
                cut = $urandom_range(1, (byte_plan.size() > 2) ? 2 : 1);
                repeat (cut)
                    void'(byte_plan.pop_back());
            end
            send_plan();
            sent += byte_plan.size();
        end
    endtask

    // sender holds back until every awaited token has arrived
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random ready, with one long hold-off on request
    initial
    begin
        token_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req       <= 1'b0;
                token_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            token_ch.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // token checker: every transfer against the oldest awaited token
    always @(posedge clk)
    begin : token_check
        token_t got;
        token_t want;
        if (rst_n && token_ch.valid && token_ch.ready)
        begin
            got = make_token(cctt_pkg::kind_t'(token_ch.kind), token_ch.arg_a, token_ch.arg_b,
                             token_ch.byte_offset, token_ch.run_first, token_ch.last_result);
            if (awaited.size() == 0)
                report_fault("unexpected token", got, got);
            else
            begin
                want = awaited.pop_front();
                if (got.kind !== want.kind || got.arg_a !== want.arg_a ||
                    got.arg_b !== want.arg_b || got.byte_offset !== want.byte_offset ||
                    got.run_first !== want.run_first || got.last_result !== want.last_result)
                    report_fault("token mismatch", want, got);
            end
        end
    end

    // stimulus
    initial
    begin
        byte_ch.valid       <= 1'b0;
        byte_ch.data_byte   <= 8'h00;
        byte_ch.record_last <= 1'b0;
        clear_parser();
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase one: sender idles now and then, receiver mostly
        tx_idle = 17;
        rx_idle = 65;
        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].data, directed_rows[i].last);
            tokenize_byte(directed_rows[i].data, directed_rows[i].last);
            if (directed_rows[i].typed)
            begin
                // single-byte record: its token at offset zero, record end at one
                await_token(make_token(directed_rows[i].kind, directed_rows[i].arg_a,
                                       16'h0000, 16'h0000, directed_rows[i].run_first,
                                       1'b0));
                await_token(make_token(cctt_pkg::KIND_REC_END, 8'h00, 16'h0000, 16'h0001,
                                       1'b0, 1'b1));
            end
            else
                queue_prediction();
        end

        // long receiver stall while bytes keep coming: queue fills, input backs up
        hold_req <= 1'b1;
        run_records(RANDOM_ITEMS / 3);
        wait_drained();

        // phase two: roles swapped
        tx_idle = 65;
        rx_idle = 17;
        run_records(RANDOM_ITEMS / 3);
        wait_drained();

        // phase three: no idling on either side
        tx_idle = 0;
        rx_idle = 0;
        run_records(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        // a name at the length limit, the byte after it is dropped, then a few tokens
        byte_plan.delete();
        add_name(cctt_pkg::NAME_LIMIT, 8'h41);
        repeat (3)
            add_token();
        send_plan();

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fault_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // guard against a hung handshake
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/cctt_pkg.sv
rtl/cctt_if.sv
rtl/cctt_front.sv
rtl/cctt_fifo.sv
rtl/cctt_back.sv
rtl/control_code_text_tokenizer_unit.sv
sim/tb_control_code_text_tokenizer_unit.sv
